/* design/fpfa_pkg.sv */
// Shared types, codes and the control program of the fixed-partition fit allocator.
`default_nettype none
package fpfa_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_PARTITIONS_DEF = 16;
   localparam int SIZE_BITS_DEF = 16;

   // Item modes.
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_REQUEST = 2'd1;
   localparam logic [1:0] MODE_FREE_ALL = 2'd2;

   // Fit strategies; the unused code behaves as first fit.
   localparam logic [1:0] STRAT_FIRST = 2'd0;
   localparam logic [1:0] STRAT_BEST = 2'd1;
   localparam logic [1:0] STRAT_WORST = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_STRATEGY = 1'b0;
   localparam logic CSR_PART_COUNT = 1'b1;

   // Program steps. The four mode steps follow the idle step in mode order.
   localparam logic [2:0] STEP_IDLE = 3'd0;
   localparam logic [2:0] STEP_LOAD = 3'd1;
   localparam logic [2:0] STEP_SCAN = 3'd2;
   localparam logic [2:0] STEP_FREE = 3'd3;
   localparam logic [2:0] STEP_NOP = 3'd4;
   localparam logic [2:0] STEP_GRANT = 3'd5;
   localparam logic [2:0] STEP_EMIT = 3'd6;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] partition_index;
      logic [15:0] size_value;
   } req_type;

   typedef struct packed {
      logic granted;
      logic [3:0] chosen_partition;
      logic [15:0] chosen_size;
      logic [7:0] request_number;
   } rsp_type;

   // Jump conditions of a control word.
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_SCAN_END,
      COND_RSP_FREE
   } cond_type;

   // One control word of the program.
   typedef struct packed {
      logic ready;
      logic load_wr;
      logic scan;
      logic free_all;
      logic grant;
      logic emit;
      cond_type cond;
      logic [2:0] target;
   } ctrl_word_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic accept;
      logic [1:0] mode;
      logic scan_end;
      logic rsp_free;
   } seq_status_type;

   // The control program. A word jumps to its target when its condition holds
   // and otherwise repeats; the accept condition adds the item's mode.
   function automatic ctrl_word_type prog_word(input logic [2:0] step);
      ctrl_word_type w;
      w = '{ready: 1'b0, load_wr: 1'b0, scan: 1'b0, free_all: 1'b0, grant: 1'b0,
            emit: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.ready = 1'b1;
            w.cond = COND_ACCEPT;
            w.target = STEP_LOAD;
         end
         STEP_LOAD: begin
            w.load_wr = 1'b1;
            w.target = STEP_EMIT;
         end
         STEP_SCAN: begin
            w.scan = 1'b1;
            w.cond = COND_SCAN_END;
            w.target = STEP_GRANT;
         end
         STEP_FREE: begin
            w.free_all = 1'b1;
            w.target = STEP_EMIT;
         end
         STEP_NOP: begin
            w.target = STEP_EMIT;
         end
         STEP_GRANT: begin
            w.grant = 1'b1;
            w.target = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit = 1'b1;
            w.cond = COND_RSP_FREE;
            w.target = STEP_IDLE;
         end
         default: begin
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

/* design/fixed_partition_fit_allocator.sv */
// Top level of the fixed-partition fit allocator: partition table, scan datapath, ports.
// A load, free-all or unused-mode word gives its result word without a scan; a request first
// scans up to partition_count entries, saturated at the table depth (first fit stops early).
// One word in flight: a new word is accepted only after the last one's result is registered.
// Reset clears the used flags, the request counter, the configuration and the output valid;
// sizes are not cleared.
`default_nettype none
module fixed_partition_fit_allocator #(
   parameter int MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
   parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire fpfa_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      fpfa_pkg::rsp_type rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [4:0]       csr_wdata
);

   localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

   fpfa_pkg::ctrl_word_type  ctrl;
   fpfa_pkg::seq_status_type status;

   logic [1:0]            strategy_ff;
   logic [4:0]            part_count_ff;
   logic [3:0]            pidx_ff;
   logic [SIZE_BITS-1:0]  sval_ff;
   logic [SIZE_BITS-1:0]  size_mem [MAX_PARTITIONS];
   logic [SIZE_BITS-1:0]  rd_data_ff;
   logic [MAX_PARTITIONS-1:0] used_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic [IDX_W-1:0]      cnt_idx;
   logic [IDX_W-1:0]      pick_ff;
   logic [SIZE_BITS-1:0]  best_ff;
   logic                  found_ff;
   logic [7:0]            count_ff;
   logic [7:0]            count_in;
   logic [7:0]            num_ff;
   logic                  rsp_valid_ff;
   fpfa_pkg::rsp_type     rsp_ff;
   logic                  accept;
   logic                  load_ok;
   logic [IDX_W-1:0]      load_idx;
   logic [31:0]           eff_n;
   logic                  first_fit;
   logic                  scan_end;
   logic                  hit;
   logic                  better;
   logic                  rsp_free;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= fpfa_pkg::STRAT_FIRST;
         part_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            fpfa_pkg::CSR_STRATEGY:   strategy_ff <= csr_wdata[1:0];
            fpfa_pkg::CSR_PART_COUNT: part_count_ff <= csr_wdata;
            default:                  strategy_ff <= strategy_ff;
         endcase
      end
   end

   // Sequencer.
   fpfa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_ready = ctrl.ready;
   assign accept = req_valid && ctrl.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign status = '{accept: accept, mode: req_data.mode, scan_end: scan_end,
                     rsp_free: rsp_free};

   // Item capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         pidx_ff <= req_data.partition_index;
         sval_ff <= SIZE_BITS'(req_data.size_value);
      end
   end

   // Scan limit: the partition count saturates at the table depth.
   assign eff_n = (32'(part_count_ff) > 32'(MAX_PARTITIONS)) ? 32'(MAX_PARTITIONS)
                                                             : 32'(part_count_ff);
   assign first_fit = (strategy_ff != fpfa_pkg::STRAT_BEST) &&
                      (strategy_ff != fpfa_pkg::STRAT_WORST);
   assign scan_end = (32'(cnt_ff) >= eff_n) || (found_ff && first_fit);
   assign cnt_idx = cnt_ff[IDX_W-1:0];

   // Entry under the scan: free, large enough, and better than the pick so far.
   assign hit = !used_ff[cnt_idx] && (rd_data_ff >= sval_ff);
   assign better = !found_ff ||
                   ((strategy_ff == fpfa_pkg::STRAT_BEST) && (rd_data_ff < best_ff)) ||
                   ((strategy_ff == fpfa_pkg::STRAT_WORST) && (rd_data_ff > best_ff));

   // Scan counter; the table read is addressed with its next value, so the read data matches it.
   always_comb begin
      if (accept) begin
         cnt_in = '0;
      end else if (ctrl.scan && !scan_end) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Partition size table: one write port for loads, one registered read for the scan.
   assign load_ok = 32'(pidx_ff) < 32'(MAX_PARTITIONS);
   assign load_idx = IDX_W'(pidx_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load_wr && load_ok) begin
         size_mem[load_idx] <= sval_ff;
      end
      rd_data_ff <= size_mem[cnt_in[IDX_W-1:0]];
   end

   // Best candidate so far.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (accept) begin
         found_ff <= 1'b0;
      end else if (ctrl.scan && !scan_end && hit && better) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scan && !scan_end && hit && better) begin
         pick_ff <= cnt_idx;
         best_ff <= rd_data_ff;
      end
   end

   // Used flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (ctrl.free_all) begin
         used_ff <= '0;
      end else if (ctrl.load_wr && load_ok) begin
         used_ff[load_idx] <= 1'b0;
      end else if (ctrl.grant && found_ff) begin
         used_ff[pick_ff] <= 1'b1;
      end
   end

   // Request counter and the number reported for the current item.
   always_comb begin
      if (ctrl.free_all) begin
         count_in = '0;
      end else if (ctrl.grant) begin
         count_in = count_ff + 8'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         num_ff <= (req_data.mode == fpfa_pkg::MODE_FREE_ALL) ? 8'd0 : count_ff;
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit && rsp_free) begin
         rsp_ff.granted <= found_ff;
         rsp_ff.chosen_partition <= found_ff ? 4'(pick_ff) : 4'd0;
         rsp_ff.chosen_size <= found_ff ? 16'(best_ff) : 16'd0;
         rsp_ff.request_number <= num_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // The granted partition was free when it was taken.
   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      (ctrl.grant && found_ff) |-> !used_ff[pick_ff])
      else $error("granted partition already in use");

   // The granted partition is marked used afterwards.
   a_grant_marks: assert property (@(posedge clock) disable iff (reset)
      (ctrl.grant && found_ff) |=> used_ff[$past(pick_ff)])
      else $error("granted partition not marked used");

   // Every request takes exactly one request number.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ctrl.grant |=> (count_ff == 8'($past(count_ff) + 8'd1)))
      else $error("request counter did not advance by one");

   // The scan never runs past the table.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      ctrl.scan |-> (32'(cnt_ff) <= 32'(MAX_PARTITIONS)))
      else $error("scan counter beyond table depth");

endmodule
`default_nettype wire

/* design/fpfa_seq.sv */
// Step counter and control program sequencer of the fit allocator.
`default_nettype none
module fpfa_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fpfa_pkg::seq_status_type status,
   output      fpfa_pkg::ctrl_word_type  ctrl
);

   logic [2:0] step_ff;
   logic [2:0] step_in;
   logic       take;

   // Control word of the current step.
   assign ctrl = fpfa_pkg::prog_word(step_ff);

   // Jump condition of the current word.
   always_comb begin
      case (ctrl.cond)
         fpfa_pkg::COND_ALWAYS:   take = 1'b1;
         fpfa_pkg::COND_ACCEPT:   take = status.accept;
         fpfa_pkg::COND_SCAN_END: take = status.scan_end;
         fpfa_pkg::COND_RSP_FREE: take = status.rsp_free;
         default:                 take = 1'b1;
      endcase
   end

   // Dispatch on the mode when an item is taken, otherwise jump or repeat.
   always_comb begin
      if (!take) begin
         step_in = step_ff;
      end else if (ctrl.cond == fpfa_pkg::COND_ACCEPT) begin
         step_in = ctrl.target + {1'b0, status.mode};
      end else begin
         step_in = ctrl.target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= fpfa_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

/* verif/tb_fixed_partition_fit_allocator.sv */
// Self-checking testbench for the fixed-partition fit allocator: directed and random words.
`timescale 1ns / 1ps
module tb_fixed_partition_fit_allocator;

   // Codes with no name in the package.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] STRAT_UNUSED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int IDLE_PERCENT = 37;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   fpfa_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   fpfa_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [4:0] csr_wdata = '0;

   // Shadow copy of the partition table and the configuration.
   logic [15:0] part_size [fpfa_pkg::MAX_PARTITIONS_DEF];
   logic [15:0] part_used = '0;
   logic [7:0] req_count = '0;
   logic [1:0] cfg_strategy = fpfa_pkg::STRAT_FIRST;
   logic [4:0] cfg_part_count = '0;

   fpfa_pkg::req_type pending_words [$];
   fpfa_pkg::rsp_type grant_expect_q [$];
   bit word_on_bus = 1'b0;
   bit no_idle = 1'b0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int errors = 0;

   fixed_partition_fit_allocator u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one input word to the shadow table and returns the result word it causes.
   function automatic fpfa_pkg::rsp_type alloc_predict(input fpfa_pkg::req_type item);
      fpfa_pkg::rsp_type res;
      int n;
      bit found;
      bit first_fit;
      int pick;
      res = '0;
      res.request_number = req_count;
      case (item.mode)
         fpfa_pkg::MODE_LOAD: begin
            part_size[item.partition_index] = item.size_value;
            part_used[item.partition_index] = 1'b0;
         end
         fpfa_pkg::MODE_FREE_ALL: begin
            part_used = '0;
            req_count = '0;
            res.request_number = '0;
         end
         fpfa_pkg::MODE_REQUEST: begin
            n = (cfg_part_count > fpfa_pkg::MAX_PARTITIONS_DEF) ? fpfa_pkg::MAX_PARTITIONS_DEF
                                                                : cfg_part_count;
            first_fit = (cfg_strategy != fpfa_pkg::STRAT_BEST) &&
                        (cfg_strategy != fpfa_pkg::STRAT_WORST);
            found = 1'b0;
            pick = 0;
            for (int j = 0; j < n; j++) begin
               if (!part_used[j] && part_size[j] >= item.size_value) begin
                  if (!found) begin
                     found = 1'b1;
                     pick = j;
                     if (first_fit) break;
                  end else if (cfg_strategy == fpfa_pkg::STRAT_BEST &&
                               part_size[j] < part_size[pick]) begin
                     pick = j;
                  end else if (cfg_strategy == fpfa_pkg::STRAT_WORST &&
                               part_size[j] > part_size[pick]) begin
                     pick = j;
                  end
               end
            end
            if (found) begin
               part_used[pick] = 1'b1;
               res.granted = 1'b1;
               res.chosen_partition = pick[3:0];
               res.chosen_size = part_size[pick];
            end
            req_count = req_count + 8'd1;
         end
         default: begin
            // The unused mode leaves the table alone.
         end
      endcase
      return res;
   endfunction

   // Sender: offers pending words, idling at random, and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            grant_expect_q.push_back(alloc_predict(req_data));
            word_on_bus = 1'b0;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
               word_on_bus = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result word and drives ready, with an occasional long hold-off.
   always @(posedge clock) begin : rsp_side
      fpfa_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (grant_expect_q.size() == 0) begin
               $error("result word with no expectation waiting");
               errors++;
            end else begin
               want = grant_expect_q.pop_front();
               if (rsp_data.granted !== want.granted) begin
                  $error("granted: expected %0d, got %0d", want.granted, rsp_data.granted);
                  errors++;
               end
               if (rsp_data.chosen_partition !== want.chosen_partition) begin
                  $error("chosen_partition: expected %0d, got %0d",
                         want.chosen_partition, rsp_data.chosen_partition);
                  errors++;
               end
               if (rsp_data.chosen_size !== want.chosen_size) begin
                  $error("chosen_size: expected %0d, got %0d",
                         want.chosen_size, rsp_data.chosen_size);
                  errors++;
               end
               if (rsp_data.request_number !== want.request_number) begin
                  $error("request_number: expected %0d, got %0d",
                         want.request_number, rsp_data.request_number);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Writes one configuration register; only called while the block is idle.
   task automatic csr_write(input logic idx, input logic [4:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == fpfa_pkg::CSR_STRATEGY) cfg_strategy = value[1:0];
      else cfg_part_count = value;
   endtask

   task automatic push_word(input logic [1:0] mode, input logic [3:0] idx,
                            input logic [15:0] size);
      fpfa_pkg::req_type item;
      item.mode = mode;
      item.partition_index = idx;
      item.size_value = size;
      pending_words.push_back(item);
   endtask

   // Waits until every word has been sent and answered, then lets the block settle.
   task automatic drain(input int settle);
      while (pending_words.size() != 0 || word_on_bus || grant_expect_q.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Random words with sizes drawn mostly from a small pool, so that fits and ties happen.
   task automatic queue_random(input int count, input bit allow_free);
      fpfa_pkg::req_type item;
      logic [15:0] pool [4];
      int r;
      for (int k = 0; k < 4; k++)
         pool[k] = (k < 2) ? 16'($urandom_range(255)) : 16'($urandom);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         item.partition_index = 4'($urandom_range(15));
         case ($urandom_range(9))
            0, 1, 2, 3, 4: item.size_value = pool[2'($urandom_range(3))];
            5: item.size_value = pool[2'($urandom_range(3))] - 16'($urandom_range(2));
            6: item.size_value = '0;
            7: item.size_value = 16'hFFFF;
            default: item.size_value = 16'($urandom);
         endcase
         if (r < 58) item.mode = fpfa_pkg::MODE_REQUEST;
         else if (r < 86) item.mode = fpfa_pkg::MODE_LOAD;
         else if (r < 93) item.mode = allow_free ? fpfa_pkg::MODE_FREE_ALL
                                                 : fpfa_pkg::MODE_REQUEST;
         else item.mode = MODE_UNUSED;
         pending_words.push_back(item);
      end
   endtask

   // Main sequence: reset, directed phases, random phases, counter wrap phase.
   initial begin : stim
      logic [15:0] load_sizes [16];
      logic [1:0] strat_cycle [4];
      logic [4:0] count_val;
      load_sizes = '{16'h0000, 16'hFFFF, 16'd100, 16'd50, 16'd200, 16'd50, 16'd300, 16'd1,
                     16'hFFFF, 16'd7, 16'hAAAA, 16'h5555, 16'h1234, 16'h8000, 16'h7FFF, 16'd2};
      strat_cycle = '{fpfa_pkg::STRAT_FIRST, fpfa_pkg::STRAT_BEST, fpfa_pkg::STRAT_WORST,
                      STRAT_UNUSED};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: load all partitions, a request with none enabled, an unused-mode word.
      for (int i = 0; i < 16; i++) push_word(fpfa_pkg::MODE_LOAD, i[3:0], load_sizes[i]);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'd0);
      push_word(MODE_UNUSED, 4'd15, 16'hFFFF);
      drain(4);

      // Best fit with a saturated count; equal sizes go to the lower index.
      csr_write(fpfa_pkg::CSR_STRATEGY, fpfa_pkg::STRAT_BEST);
      csr_write(fpfa_pkg::CSR_PART_COUNT, 5'd31);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'd50);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'd50);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'd50);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'hFFFF);
      drain(4);

      // Worst fit until nothing fits, a reload that frees one entry, then free all.
      csr_write(fpfa_pkg::CSR_STRATEGY, fpfa_pkg::STRAT_WORST);
      csr_write(fpfa_pkg::CSR_PART_COUNT, 5'd16);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'd1);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'hFFFF);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'hFFFF);
      push_word(fpfa_pkg::MODE_LOAD, 4'd1, 16'hFFFF);
      push_word(fpfa_pkg::MODE_FREE_ALL, 4'd0, 16'd0);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'd0);
      drain(4);

      // The unused strategy code acts as first fit.
      csr_write(fpfa_pkg::CSR_STRATEGY, STRAT_UNUSED);
      csr_write(fpfa_pkg::CSR_PART_COUNT, 5'd5);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'd0);
      push_word(fpfa_pkg::MODE_REQUEST, 4'd0, 16'd200);
      drain(4);

      // Random phases over all strategies and counts, extremes included.
      for (int ph = 0; ph < 14; ph++) begin
         case (ph % 6)
            0: count_val = 5'd16;
            1: count_val = 5'd31;
            2: count_val = 5'd0;
            3: count_val = 5'd1;
            default: count_val = 5'($urandom_range(31));
         endcase
         csr_write(fpfa_pkg::CSR_STRATEGY, strat_cycle[ph % 4]);
         csr_write(fpfa_pkg::CSR_PART_COUNT, count_val);
         no_idle = (ph == 5);
         queue_random(85, 1'b1);
         if (ph == 3) hold_asked++;
         drain(4);
      end
      no_idle = 1'b0;

      // A long run without free-all so the request counter wraps.
      csr_write(fpfa_pkg::CSR_STRATEGY, fpfa_pkg::STRAT_BEST);
      csr_write(fpfa_pkg::CSR_PART_COUNT, 5'd16);
      queue_random(500, 1'b0);
      drain(40);

      if (errors == 0) begin
         $display("tb_fixed_partition_fit_allocator OK");
      end else begin
         $display("tb_fixed_partition_fit_allocator NOT OK");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #2000000;
      $display("tb_fixed_partition_fit_allocator NOT OK");
      $finish;
   end

endmodule
